// File: rtl/rlq_pkg.sv
// shared types and constants for the ramp level quantizer
// no dependencies; imported by every module of the block
package rlq_pkg;

    localparam int LEVEL_W  = 8;
    localparam int TARGET_W = 16;
    localparam int INDEX_W  = 2;
    localparam int DIV_CNT_W = $clog2(LEVEL_W);

    localparam logic [INDEX_W-1:0] REG_FLOOR   = 2'd0;
    localparam logic [INDEX_W-1:0] REG_CEILING = 2'd1;
    localparam logic [INDEX_W-1:0] REG_STEPS   = 2'd2;

    localparam logic [LEVEL_W-1:0] FLOOR_RST   = 8'd1;
    localparam logic [LEVEL_W-1:0] CEILING_RST = 8'd150;
    localparam logic [LEVEL_W-1:0] STEPS_RST   = 8'd7;

    // commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic decide;
        logic div_start;
        logic div_step;
        logic scan_step;
        logic take_level;
        logic load_out;
    } t_dp_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic early_hit;
        logic div_last;
        logic level_hit;
        logic scan_last;
    } t_dp_sts;

endpackage

// File: rtl/rlq_ctrl.sv
// sequencer for the ramp level quantizer: accept, decide, divide, scan, deliver
// depends on rlq_pkg
module rlq_ctrl
    import rlq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    output logic    o_valid,
    input  logic    i_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_CHECK   = 5'b00010,
        S_DIVIDE  = 5'b00100,
        S_SCAN    = 5'b01000,
        S_DELIVER = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_ready;
    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.decide = 1'b1;
                if (i_sts.early_hit) begin
                    n_state = S_DELIVER;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIVIDE;
                end
            end
            S_DIVIDE: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.level_hit || i_sts.scan_last) begin
                    o_cmd.take_level = 1'b1;
                    n_state          = S_DELIVER;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_DELIVER: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// File: rtl/rlq_dp.sv
// datapath: ramp registers, early decisions, restoring divider and level scan
// depends on rlq_pkg
module rlq_dp
    import rlq_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [INDEX_W-1:0]  i_cfg_index,
    input  logic [LEVEL_W-1:0]  i_cfg_data,
    input  logic [TARGET_W-1:0] i_target,
    input  t_dp_cmd             i_cmd,
    output t_dp_sts             o_sts,
    output logic [LEVEL_W-1:0]  o_chosen_level
);

    logic [LEVEL_W-1:0]   r_floor, r_ceiling, r_steps;
    logic [TARGET_W-1:0]  r_target;
    logic [LEVEL_W-1:0]   r_result, r_chosen;
    logic [LEVEL_W-1:0]   r_rem, r_quo;
    logic [DIV_CNT_W-1:0] r_div_cnt;
    logic [LEVEL_W-1:0]   r_q, r_r, r_i;

    logic [LEVEL_W:0]     mid_sum;
    logic                 tgt_ge_ceil, tgt_le_floor;
    logic                 early_hit;
    logic [LEVEL_W-1:0]   early_level;
    logic [LEVEL_W-1:0]   range, divisor, radius;
    logic [LEVEL_W:0]     trial;
    logic                 trial_ge;
    logic [LEVEL_W:0]     level_sum;
    logic [LEVEL_W-1:0]   level;
    logic [LEVEL_W:0]     diff;
    logic [LEVEL_W-1:0]   level_gap;
    logic [LEVEL_W:0]     r_sum;
    logic                 r_wrap;

    // early decisions, in priority order
    always_comb begin
        mid_sum      = {1'b0, r_floor} + {1'b0, r_ceiling};
        tgt_ge_ceil  = $signed(r_target) >= $signed({{(TARGET_W-LEVEL_W){1'b0}}, r_ceiling});
        tgt_le_floor = $signed(r_target) <= $signed({{(TARGET_W-LEVEL_W){1'b0}}, r_floor});
        early_hit    = 1'b1;
        early_level  = r_target[LEVEL_W-1:0];
        if (r_steps == LEVEL_W'(1)) begin
            early_level = mid_sum[LEVEL_W:1];
        end else if (tgt_ge_ceil) begin
            early_level = r_ceiling;
        end else if (tgt_le_floor) begin
            early_level = r_floor;
        end else if (r_steps == '0) begin
            early_level = r_target[LEVEL_W-1:0];
        end else begin
            early_hit = 1'b0;
        end
    end

    assign range   = r_ceiling - r_floor;
    assign divisor = r_steps - LEVEL_W'(1);
    assign radius  = r_quo >> 1;

    // one restoring divide step per cycle
    assign trial    = {r_rem, r_quo[LEVEL_W-1]};
    assign trial_ge = trial >= {1'b0, divisor};

    // current level and its distance; target lies inside the ramp here
    assign level_sum = {1'b0, r_floor} + {1'b0, r_q};
    assign level     = level_sum[LEVEL_W-1:0];
    assign diff      = {1'b0, r_target[LEVEL_W-1:0]} - {1'b0, level};
    assign level_gap = diff[LEVEL_W] ? LEVEL_W'(-diff) : diff[LEVEL_W-1:0];

    // incremental quotient of i*range/div: remainder stays below the divisor
    assign r_sum  = {1'b0, r_r} + {1'b0, r_rem};
    assign r_wrap = r_sum >= {1'b0, divisor};

    assign o_sts.early_hit = early_hit;
    assign o_sts.div_last  = (r_div_cnt == DIV_CNT_W'(LEVEL_W - 1));
    assign o_sts.level_hit = (level_gap <= radius);
    assign o_sts.scan_last = (r_i == divisor);

    assign o_chosen_level = r_chosen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_floor   <= FLOOR_RST;
            r_ceiling <= CEILING_RST;
            r_steps   <= STEPS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_FLOOR:   r_floor   <= i_cfg_data;
                REG_CEILING: r_ceiling <= i_cfg_data;
                REG_STEPS:   r_steps   <= i_cfg_data;
                default:     ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_target <= i_target;
        end
        if (i_cmd.decide && early_hit) begin
            r_result <= early_level;
        end
        if (i_cmd.take_level) begin
            r_result <= level;
        end
        if (i_cmd.load_out) begin
            r_chosen <= r_result;
        end
        if (i_cmd.div_start) begin
            r_rem     <= '0;
            r_quo     <= range;
            r_div_cnt <= '0;
            r_q       <= '0;
            r_r       <= '0;
            r_i       <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem     <= trial_ge ? LEVEL_W'(trial - {1'b0, divisor}) : trial[LEVEL_W-1:0];
            r_quo     <= {r_quo[LEVEL_W-2:0], trial_ge};
            r_div_cnt <= r_div_cnt + DIV_CNT_W'(1);
        end
        if (i_cmd.scan_step) begin
            r_i <= r_i + LEVEL_W'(1);
            if (r_wrap) begin
                r_r <= LEVEL_W'(r_sum - {1'b0, divisor});
                r_q <= r_q + r_quo + LEVEL_W'(1);
            end else begin
                r_r <= r_sum[LEVEL_W-1:0];
                r_q <= r_q + r_quo;
            end
        end
    end

endmodule

// File: rtl/ramp_level_quantizer_unit.sv
// the single step, clamp and smooth cases go from check straight to deliver; any other request
// also runs the divider and then scans levels 0 to k, k (0 to step_count - 1) being the chosen index
// one request is handled at a time, and the level scan sets the worst case;
// a new request is taken as soon as the previous result sits in the output register
// reset (synchronous, active low) clears control and loads floor 1, ceiling 150, steps 7
module ramp_level_quantizer_unit
    import rlq_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // request channel
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [TARGET_W-1:0] i_target_level,
    // result channel
    output logic                o_valid,
    input  logic                i_ready,
    output logic [LEVEL_W-1:0]  o_chosen_level,
    // configuration write channel
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [INDEX_W-1:0]  i_cfg_index,
    input  logic [LEVEL_W-1:0]  i_cfg_data
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // registers must only be written while the block is idle; the block does not enforce this, so always ready
    assign o_cfg_ready = 1'b1;

    // sequencer: a request walks check, then divide and scan unless an early decision holds, then deliver
    rlq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // datapath holds the ramp registers, the divider and the output register
    rlq_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_valid && o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_target       (i_target_level),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_chosen_level (o_chosen_level)
    );

    // an accepted request keeps the input closed for the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("request channel open right after an accepted request");

    // loading the output register always presents a result
    a_load_shows_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |=> o_valid)
        else $error("output load did not raise valid");

    // never load the output while an untaken result is still held
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> (!o_valid || i_ready))
        else $error("pending result overwritten");

    // divider and scan never run in the same cycle
    a_div_scan_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.div_step && cmd.scan_step))
        else $error("divide and scan steps overlap");

endmodule
